### hw/rtl/melody_tone_synth_macros.svh
// Assertion macros shared by the tone synthesizer RTL.
`ifndef MELODY_TONE_SYNTH_MACROS_SVH
`define MELODY_TONE_SYNTH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mts_pkg.sv
// Shared types, codes, constants and table builders for the tone synthesizer.
package mts_pkg;

   // request kinds
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // accidental codes
   localparam logic [1:0] ACC_NATURAL  = 2'd0;
   localparam logic [1:0] ACC_SHARP    = 2'd1;
   localparam logic [1:0] ACC_FLAT     = 2'd2;
   localparam logic [1:0] ACC_RESERVED = 2'd3;

   // note letters
   localparam logic [2:0] LETTER_A = 3'd0;
   localparam logic [2:0] LETTER_B = 3'd1;
   localparam logic [2:0] LETTER_C = 3'd2;
   localparam logic [2:0] LETTER_D = 3'd3;
   localparam logic [2:0] LETTER_E = 3'd4;
   localparam logic [2:0] LETTER_F = 3'd5;
   localparam logic [2:0] LETTER_G = 3'd6;

   // response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_NOTE = 2'd1;
   localparam logic [1:0] STATUS_IDLE     = 2'd2;

   // field and datapath widths
   localparam int AMP_W    = 15;
   localparam int MS_W     = 16;
   localparam int COUNT_W  = 22;
   localparam int SINE_W   = 31;
   localparam int SAMPLE_W = 16;
   localparam int SEMI_W   = 4;
   localparam int OCT_W    = 4;

   localparam logic [AMP_W-1:0] AMP_RESET = 15'd25000;

   // ceil(ms / 10) via reciprocal: (ms + 9) * 104858 >> 20, exact for 17-bit values
   localparam int               RECIP_SHIFT = 20;
   localparam logic [16:0]      RECIP_10    = 17'd104858;
   localparam logic [COUNT_W-1:0] SAMPLES_PER_MS = 22'd44;

   // Q30 sine table constants
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned SINE_DIVS [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   // 44100 Hz times 10^6 times 16 (frequencies are in micro-Hz; the 16 offsets the octave-4 base)
   localparam longint unsigned STEP_DIVISOR = 64'd705600000000;

   // octave-4 frequencies in micro-Hz, C up to B
   localparam longint unsigned OCT4_UHZ [12] = '{
      64'd261625565, 64'd277182631, 64'd293664768, 64'd311126984,
      64'd329627557, 64'd349228231, 64'd369994423, 64'd391995436,
      64'd415304698, 64'd440000000, 64'd466163762, 64'd493883301
   };

   // per-request control carried alongside the sine lookup
   typedef struct packed {
      logic       sine_en;
      logic       negate;
      logic       last;
      logic [1:0] status;
   } s1_ctrl_type;

   // semitone of a natural letter, counted from C
   function automatic logic [SEMI_W-1:0] letter_semitone(input logic [2:0] letter);
      logic [SEMI_W-1:0] semi;
      case (letter)
         LETTER_A: semi = 4'd9;
         LETTER_B: semi = 4'd11;
         LETTER_C: semi = 4'd0;
         LETTER_D: semi = 4'd2;
         LETTER_E: semi = 4'd4;
         LETTER_F: semi = 4'd5;
         LETTER_G: semi = 4'd7;
         default:  semi = 4'd0;
      endcase
      return semi;
   endfunction

   // phase step = round(f * 2^phase_bits / 44100), evaluated at elaboration
   function automatic longint unsigned calc_step(input int semi, input int oct,
                                                  input int phase_bits);
      longint unsigned x;
      longint unsigned q;
      longint unsigned r;
      int              i;
      x = OCT4_UHZ[semi] << oct;
      q = x / STEP_DIVISOR;
      r = x % STEP_DIVISOR;
      for (i = 0; i < phase_bits; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= STEP_DIVISOR) begin
            r = r - STEP_DIVISOR;
            q = q | 64'd1;
         end
      end
      if (2 * r >= STEP_DIVISOR) begin
         q = q + 64'd1;
      end
      return q;
   endfunction

   // Q30 sin(x) for x in Q30 radians, Horner-form Taylor series through x^11
   function automatic longint unsigned quarter_sine(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned r;
      int              i;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (i = 0; i < 5; i++) begin
         t = Q30_ONE - ((x2 * t) >> 30) / SINE_DIVS[i];
      end
      r = (x * t) >> 30;
      return (r > Q30_ONE) ? Q30_ONE : r;
   endfunction

endpackage

### hw/rtl/melody_tone_synth.sv
// Equal-temperament DDS tone generator: note loads, sample ticks, quarter-wave sine.
//
//   channel  dir  fields
//   req_*    in   tuser {is_rest, action}, tdata {duration_ms, octave, accidental, note_letter}
//   rsp_*    out  tdata sample, tlast note_last, tuser status
//   csr_*    in   wdata amplitude
//
// One request per cycle while the response side is not stalled. The sine table read is
// registered at the accepting edge and the amplitude multiply feeds the output register, so a
// response passes through the stage-1 register and then the output register.
// Reset is synchronous; amplitude returns to 25000 and the voice goes idle.
// A stalled response holds the output stage; the sine stage still takes one more request.
`include "melody_tone_synth_macros.svh"

module melody_tone_synth #(
   parameter int PHASE_BITS         = 32,
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [2:0] note_letter, [4:3] accidental, [8:5] octave,
                                    // [24:9] duration_ms, [31:25] zero
   input  logic [1:0]  req_tuser,   // [0] action, [1] is_rest
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample (signed)
   output logic        rsp_tlast,   // note_last
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // amplitude register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_wdata    // amplitude
);

   localparam int FRAC_W = PHASE_BITS - 2;
   localparam int KW     = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int KPROD_W = FRAC_W + KW;
   localparam int PROD_W  = mts_pkg::AMP_W + mts_pkg::SINE_W;
   localparam int STEP_IDX_W = mts_pkg::SEMI_W + mts_pkg::OCT_W;

   // ---------------------------------------------------------------
   // constant tables
   // ---------------------------------------------------------------
   logic [PHASE_BITS-1:0]      step_rom [2**STEP_IDX_W];
   logic [mts_pkg::SINE_W-1:0] sine_rom [SINE_TABLE_ENTRIES+1];

   for (genvar g = 0; g < 2**STEP_IDX_W; g++) begin : g_step
      localparam int SEMI = g / (2**mts_pkg::OCT_W);
      localparam int OCT  = g % (2**mts_pkg::OCT_W);
      if (SEMI < 12) begin : g_valid
         assign step_rom[g] = PHASE_BITS'(mts_pkg::calc_step(SEMI, OCT, PHASE_BITS));
      end else begin : g_unused
         assign step_rom[g] = '0;
      end
   end

   for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_sine
      localparam longint unsigned ANGLE =
         (longint'(g) * mts_pkg::HALF_PI_Q30) / SINE_TABLE_ENTRIES;
      assign sine_rom[g] = mts_pkg::SINE_W'(mts_pkg::quarter_sine(ANGLE));
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   logic [mts_pkg::AMP_W-1:0]    amp_ff;
   logic [PHASE_BITS-1:0]        phase_ff, phase_in;
   logic [PHASE_BITS-1:0]        step_ff, step_in;
   logic [mts_pkg::COUNT_W-1:0]  samples_ff, samples_in;
   logic                         resting_ff, resting_in;

   logic                         s1_valid_ff, s1_valid_in;
   mts_pkg::s1_ctrl_type         s1_ctrl_ff, s1_ctrl_in;
   logic [mts_pkg::SINE_W-1:0]   s1_sine_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mts_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                         rsp_last_ff;
   logic [1:0]                   rsp_status_ff;

   // ---------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------
   logic out_free, s1_move, req_accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------
   // request fields
   // ---------------------------------------------------------------
   logic                        req_action, req_rest;
   logic [2:0]                  req_letter;
   logic [1:0]                  req_acc;
   logic [mts_pkg::OCT_W-1:0]   req_oct;
   logic [mts_pkg::MS_W-1:0]    req_ms;

   assign req_action = req_tuser[0];
   assign req_rest   = req_tuser[1];
   assign req_letter = req_tdata[2:0];
   assign req_acc    = req_tdata[4:3];
   assign req_oct    = req_tdata[8:5];
   assign req_ms     = req_tdata[24:9];

   // note name check and semitone
   logic                       bad_note;
   logic [mts_pkg::SEMI_W-1:0] semi;

   always_comb begin
      bad_note = (req_letter > mts_pkg::LETTER_G) || (req_acc == mts_pkg::ACC_RESERVED) ||
                 ((req_acc == mts_pkg::ACC_FLAT) &&
                  (req_letter inside {mts_pkg::LETTER_C, mts_pkg::LETTER_F})) ||
                 ((req_acc == mts_pkg::ACC_SHARP) &&
                  (req_letter inside {mts_pkg::LETTER_B, mts_pkg::LETTER_E}));
      semi = mts_pkg::letter_semitone(req_letter);
      case (req_acc)
         mts_pkg::ACC_SHARP: semi = semi + 4'd1;
         mts_pkg::ACC_FLAT:  semi = semi - 4'd1;
         default:            semi = semi;
      endcase
   end

   // sample count: ceil(ms * 44.1) = 44 * ms + ceil(ms / 10)
   logic [16:0]                 ms_plus9;
   logic [33:0]                 tenth_prod;
   logic [mts_pkg::COUNT_W-1:0] load_count;

   assign ms_plus9   = 17'(req_ms) + 17'd9;
   assign tenth_prod = 34'(ms_plus9) * 34'(mts_pkg::RECIP_10);
   assign load_count = mts_pkg::COUNT_W'(req_ms) * mts_pkg::SAMPLES_PER_MS +
                       mts_pkg::COUNT_W'(tenth_prod[33:mts_pkg::RECIP_SHIFT]);

   // table index from the phase: quadrant in the top bits, mirrored in odd quadrants
   logic [KPROD_W-1:0] k_prod;
   logic [KW-1:0]      k_raw, sine_idx;

   assign k_prod   = KPROD_W'(phase_ff[FRAC_W-1:0]) * KPROD_W'(SINE_TABLE_ENTRIES);
   assign k_raw    = k_prod[KPROD_W-1:FRAC_W];
   assign sine_idx = phase_ff[PHASE_BITS-2] ? (KW'(SINE_TABLE_ENTRIES) - k_raw) : k_raw;

   // ---------------------------------------------------------------
   // voice state update and per-request control
   // ---------------------------------------------------------------
   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      samples_in = samples_ff;
      resting_in = resting_ff;
      s1_ctrl_in = '{sine_en: 1'b0, negate: 1'b0, last: 1'b0, status: mts_pkg::STATUS_OK};
      if (req_accept) begin
         if (req_action == mts_pkg::ACTION_LOAD) begin
            phase_in = '0;
            if (req_rest) begin
               resting_in = 1'b1;
               step_in    = '0;
               samples_in = load_count;
            end else if (bad_note) begin
               resting_in        = 1'b0;
               step_in           = '0;
               samples_in        = '0;
               s1_ctrl_in.status = mts_pkg::STATUS_BAD_NOTE;
            end else begin
               resting_in = 1'b0;
               step_in    = step_rom[{semi, req_oct}];
               samples_in = load_count;
            end
         end else if (samples_ff == '0) begin
            s1_ctrl_in.status = mts_pkg::STATUS_IDLE;
         end else begin
            if (!resting_ff) begin
               s1_ctrl_in.sine_en = 1'b1;
               s1_ctrl_in.negate  = phase_ff[PHASE_BITS-1];
               phase_in           = phase_ff + step_ff;
            end
            s1_ctrl_in.last = (samples_ff == mts_pkg::COUNT_W'(1));
            samples_in      = samples_ff - mts_pkg::COUNT_W'(1);
         end
      end
   end

   // voice state and amplitude register
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff     <= mts_pkg::AMP_RESET;
         phase_ff   <= '0;
         step_ff    <= '0;
         samples_ff <= '0;
         resting_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            amp_ff <= csr_wdata;
         end
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         samples_ff <= samples_in;
         resting_ff <= resting_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: registered sine table read
   // ---------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_sine_ff <= sine_rom[sine_idx];
      end
   end

   // ---------------------------------------------------------------
   // stage 2: amplitude scaling, rounding, sign
   // ---------------------------------------------------------------
   logic [PROD_W-1:0]            amp_prod, amp_round;
   logic [mts_pkg::SAMPLE_W-1:0] mag, sample_out;

   assign amp_prod  = PROD_W'(amp_ff) * PROD_W'(s1_sine_ff);
   assign amp_round = amp_prod + (PROD_W'(1) << 29);
   assign mag       = amp_round[30 +: mts_pkg::SAMPLE_W];

   always_comb begin
      if (!s1_ctrl_ff.sine_en) begin
         sample_out = '0;
      end else if (s1_ctrl_ff.negate) begin
         sample_out = '0 - mag;
      end else begin
         sample_out = mag;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_sample_ff <= sample_out;
         rsp_last_ff   <= s1_ctrl_ff.last;
         rsp_status_ff <= s1_ctrl_ff.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   `MTS_ASSERT_NEXT(a_load_clears_phase,
      req_accept && (req_action == mts_pkg::ACTION_LOAD),
      phase_ff == '0, "load did not clear phase")
   `MTS_ASSERT_NEXT(a_rest_holds_phase,
      req_accept && (req_action == mts_pkg::ACTION_TICK) && resting_ff,
      $stable(phase_ff), "phase moved during a rest")
   `MTS_ASSERT_NEXT(a_idle_tick_status,
      req_accept && (req_action == mts_pkg::ACTION_TICK) && (samples_ff == '0),
      (s1_ctrl_ff.status == mts_pkg::STATUS_IDLE) && !s1_ctrl_ff.sine_en,
      "idle tick not flagged")
   `MTS_ASSERT_NOW(a_flagged_is_silent,
      rsp_valid_ff && (rsp_status_ff != mts_pkg::STATUS_OK),
      (rsp_sample_ff == '0) && !rsp_last_ff, "flagged response carries audio")

endmodule
